### hdl/gng_pkg.sv
`timescale 1ns / 1ps
// Package for the Gaussian noise generator: controller states, datapath
// operations, command/status structs and the fixed-point constants.
// No dependencies.
package gng_pkg;

  // Iteration counts of the three shared loops
  localparam int unsigned LogSteps    = 30;
  localparam int unsigned SqrtSteps   = 32;
  localparam int unsigned CordicSteps = 30;
  localparam int unsigned CntBits     = 5;

  // ln(2) in Q.28, pi/2 in Q.30, inverse CORDIC gain in Q.30
  localparam logic [31:0] Ln2Q28    = 32'd186065279;
  localparam logic [31:0] HalfPiQ30 = 32'd1686629713;
  localparam logic [31:0] KQ30      = 32'd652032874;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOG_MUL,
    ST_LOG_UPD,
    ST_LN_LO,
    ST_LN_HI,
    ST_SQRT,
    ST_ANG,
    ST_X0,
    ST_XI,
    ST_CORDIC,
    ST_EMIT,
    ST_HELD
  } state_e;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_LOG_MUL,
    OP_LOG_UPD,
    OP_LN_LO,
    OP_LN_HI,
    OP_SQRT,
    OP_ANG,
    OP_X0,
    OP_XI,
    OP_CORDIC,
    OP_EMIT_NEW,
    OP_EMIT_HELD
  } dp_op_e;

  typedef struct packed {
    dp_op_e             op;
    logic [CntBits-1:0] iter;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  // atan(2^-i) in Q.30
  function automatic logic [29:0] atan_q30(input logic [CntBits-1:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0:  v = 30'd843314856;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      5'd24: v = 30'd63;
      5'd25: v = 30'd31;
      5'd26: v = 30'd15;
      5'd27: v = 30'd7;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

### hdl/gng_ctrl.sv
`timescale 1ns / 1ps
// Controller of the Gaussian noise generator: sequences the log, scale,
// square root, angle and CORDIC steps of the datapath. Depends on gng_pkg.
module gng_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  gng_pkg::sts_t sts_i,
  output gng_pkg::cmd_t cmd_o
);

  gng_pkg::state_e                    state_q, state_d;
  logic [gng_pkg::CntBits-1:0]        cnt_q, cnt_d;
  logic                               phase_q, phase_d;
  logic                               accept;

  assign accept = in_valid_i && in_ready_o;

  // State, counter and pair phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gng_pkg::ST_IDLE;
      cnt_q   <= '0;
      phase_q <= 1'b1;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    phase_d = phase_q;
    unique case (state_q)
      gng_pkg::ST_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          state_d = phase_q ? gng_pkg::ST_LOG_MUL : gng_pkg::ST_HELD;
        end
      end
      gng_pkg::ST_LOG_MUL: state_d = gng_pkg::ST_LOG_UPD;
      gng_pkg::ST_LOG_UPD: begin
        if (cnt_q == gng_pkg::CntBits'(gng_pkg::LogSteps - 1)) begin
          cnt_d   = '0;
          state_d = gng_pkg::ST_LN_LO;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = gng_pkg::ST_LOG_MUL;
        end
      end
      gng_pkg::ST_LN_LO: state_d = gng_pkg::ST_LN_HI;
      gng_pkg::ST_LN_HI: begin
        cnt_d   = '0;
        state_d = gng_pkg::ST_SQRT;
      end
      gng_pkg::ST_SQRT: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == gng_pkg::CntBits'(gng_pkg::SqrtSteps - 1)) begin
          state_d = gng_pkg::ST_ANG;
        end
      end
      gng_pkg::ST_ANG: state_d = gng_pkg::ST_X0;
      gng_pkg::ST_X0:  state_d = gng_pkg::ST_XI;
      gng_pkg::ST_XI: begin
        cnt_d   = '0;
        state_d = gng_pkg::ST_CORDIC;
      end
      gng_pkg::ST_CORDIC: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == gng_pkg::CntBits'(gng_pkg::CordicSteps - 1)) begin
          state_d = gng_pkg::ST_EMIT;
        end
      end
      gng_pkg::ST_EMIT, gng_pkg::ST_HELD: begin
        if (sts_i.out_free) begin
          phase_d = ~phase_q;
          state_d = gng_pkg::ST_IDLE;
        end
      end
      default: state_d = gng_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = gng_pkg::OP_IDLE;
    cmd_o.iter = cnt_q;
    unique case (state_q)
      gng_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && phase_q) cmd_o.op = gng_pkg::OP_LOAD;
      end
      gng_pkg::ST_LOG_MUL: cmd_o.op = gng_pkg::OP_LOG_MUL;
      gng_pkg::ST_LOG_UPD: cmd_o.op = gng_pkg::OP_LOG_UPD;
      gng_pkg::ST_LN_LO:   cmd_o.op = gng_pkg::OP_LN_LO;
      gng_pkg::ST_LN_HI:   cmd_o.op = gng_pkg::OP_LN_HI;
      gng_pkg::ST_SQRT:    cmd_o.op = gng_pkg::OP_SQRT;
      gng_pkg::ST_ANG:     cmd_o.op = gng_pkg::OP_ANG;
      gng_pkg::ST_X0:      cmd_o.op = gng_pkg::OP_X0;
      gng_pkg::ST_XI:      cmd_o.op = gng_pkg::OP_XI;
      gng_pkg::ST_CORDIC:  cmd_o.op = gng_pkg::OP_CORDIC;
      gng_pkg::ST_EMIT: begin
        if (sts_i.out_free) cmd_o.op = gng_pkg::OP_EMIT_NEW;
      end
      gng_pkg::ST_HELD: begin
        if (sts_i.out_free) cmd_o.op = gng_pkg::OP_EMIT_HELD;
      end
      default: cmd_o.op = gng_pkg::OP_IDLE;
    endcase
  end

`ifndef SYNTH
  // A second request of a pair never starts the math
  a_held_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !phase_q) |=> (state_q == gng_pkg::ST_HELD))
    else $error("second request did not go to held reply");

  // Phase flips only when a result is loaded
  a_phase_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op != gng_pkg::OP_EMIT_NEW && cmd_o.op != gng_pkg::OP_EMIT_HELD)
    |=> $stable(phase_q))
    else $error("phase changed without a result");

  // CORDIC counter stays inside the angle table
  a_cordic_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gng_pkg::ST_CORDIC) |-> (cnt_q < gng_pkg::CntBits'(gng_pkg::CordicSteps)))
    else $error("CORDIC counter out of range");

  // A fresh pair is emitted only after the CORDIC loop
  a_emit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == gng_pkg::ST_EMIT) |-> ($past(state_q) == gng_pkg::ST_CORDIC))
    else $error("emit entered out of order");
`endif

endmodule

### hdl/gng_dp.sv
`timescale 1ns / 1ps
// Datapath of the Gaussian noise generator: shared 32x32 multiplier, log2
// by squaring, bit-serial square root, CORDIC and output register. Uses gng_pkg.
module gng_dp #(
  parameter int unsigned UNIFORM_BITS = 16,
  parameter int unsigned FRAC_BITS    = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gng_pkg::cmd_t      cmd_i,
  output gng_pkg::sts_t      sts_o,
  input  logic        [15:0] uniform_a_i,
  input  logic        [15:0] uniform_b_i,
  output logic        [15:0] sample_o,
  output logic               fresh_pair_o,
  output logic               out_valid_o,
  input  logic               out_ready_i
);

  localparam int unsigned OutShift = 28 - FRAC_BITS;
  localparam int unsigned AngShift = 32 - UNIFORM_BITS;
  localparam logic [35:0] FullQ30  = 36'(UNIFORM_BITS) << 30;

  // Working registers
  logic [4:0]         e_q;
  logic [29:0]        frac_q;
  logic [30:0]        lx_q;
  logic [63:0]        prod_q;
  logic [31:0]        p_q;
  logic [61:0]        v_q;
  logic [62:0]        res_q;
  logic signed [33:0] cx_q, cy_q;
  logic signed [32:0] cz_q;
  logic [15:0]        held_q;
  logic [15:0]        out_sample_q;
  logic               out_fresh_q;
  logic               out_valid_q;

  // Input mapping: masked uniforms, leading one and normalized mantissa
  logic [15:0] ua_m, ub_m;
  logic [16:0] m_w;
  logic [4:0]  e_w;
  logic [30:0] xn_w;
  logic [16:0] bp_w;
  logic [63:0] pw_w;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      ua_m[i] = (i < UNIFORM_BITS) ? uniform_a_i[i] : 1'b0;
      ub_m[i] = (i < UNIFORM_BITS) ? uniform_b_i[i] : 1'b0;
    end
    m_w = {1'b0, ua_m} + 17'd1;
    e_w = '0;
    for (int i = 0; i < 17; i++) begin
      if (m_w[i]) e_w = 5'(i);
    end
    xn_w = 31'(m_w) << (5'd30 - e_w);
    bp_w = {1'b0, ub_m} + 17'd1;
    pw_w = 64'(bp_w) << AngShift;
  end

  // -log2(a) in Q.30, clamped at zero
  logic [35:0] lg_w, l_w;
  assign lg_w = {1'b0, e_q, frac_q};
  assign l_w  = (lg_w >= FullQ30) ? '0 : FullQ30 - lg_w;

  // Shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      gng_pkg::OP_LOG_MUL: begin
        mul_a = {1'b0, lx_q};
        mul_b = {1'b0, lx_q};
      end
      gng_pkg::OP_LN_LO: begin
        mul_a = 32'(l_w[17:0]);
        mul_b = gng_pkg::Ln2Q28;
      end
      gng_pkg::OP_LN_HI: begin
        mul_a = 32'(l_w[35:18]);
        mul_b = gng_pkg::Ln2Q28;
      end
      gng_pkg::OP_ANG: begin
        mul_a = {2'b00, p_q[29:0]};
        mul_b = gng_pkg::HalfPiQ30;
      end
      gng_pkg::OP_X0: begin
        mul_a = res_q[31:0];
        mul_b = gng_pkg::KQ30;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // Log squaring step: keep x in [1,2), shift out a fraction bit
  logic [31:0] sq_w;
  logic [30:0] sqx_w;
  assign sq_w  = prod_q[61:30];
  assign sqx_w = sq_w[31] ? sq_w[31:1] : sq_w[30:0];

  // Scale by 2 ln 2, giving -2 ln a in Q.30
  logic [63:0] lnsum_w;
  logic [35:0] t_w;
  assign lnsum_w = prod_q + (mul_p << 18);
  assign t_w     = lnsum_w[62:27];

  // One square root digit
  logic [62:0] bit_w;
  logic [63:0] trial_w;
  logic        take_w;
  assign bit_w   = 63'(1) << (6'd62 - {cmd_i.iter, 1'b0});
  assign trial_w = {1'b0, res_q} + {1'b0, bit_w};
  assign take_w  = {2'b00, v_q} >= trial_w;

  // One CORDIC rotation: dx_w moves x, dy_w moves y
  logic signed [33:0] dx_w, dy_w;
  logic signed [32:0] at_w;
  assign dx_w = cy_q >>> cmd_i.iter;
  assign dy_w = cx_q >>> cmd_i.iter;
  assign at_w = $signed({3'b000, gng_pkg::atan_q30(cmd_i.iter)});

  // Quadrant map and conversion to output format
  function automatic logic [15:0] to_sample(input logic signed [33:0] q);
    logic signed [34:0] r;
    logic signed [34:0] v;
    r = 35'(q) + 35'(35'sd1 <<< (OutShift - 1));
    v = r >>> OutShift;
    if (v > 35'sd32767) return 16'h7FFF;
    if (v < -35'sd32768) return 16'h8000;
    return v[15:0];
  endfunction

  logic signed [33:0] sin_w, cos_w;
  always_comb begin
    unique case (p_q[31:30])
      2'd0: begin cos_w = cx_q;  sin_w = cy_q;  end
      2'd1: begin cos_w = -cy_q; sin_w = cx_q;  end
      2'd2: begin cos_w = -cx_q; sin_w = -cy_q; end
      default: begin cos_w = cy_q; sin_w = -cx_q; end
    endcase
  end

  // Arithmetic registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      gng_pkg::OP_LOAD: begin
        e_q    <= e_w;
        lx_q   <= xn_w;
        frac_q <= '0;
        p_q    <= pw_w[31:0];
      end
      gng_pkg::OP_LOG_MUL, gng_pkg::OP_LN_LO, gng_pkg::OP_ANG: begin
        prod_q <= mul_p;
      end
      gng_pkg::OP_LOG_UPD: begin
        lx_q   <= sqx_w;
        frac_q <= {frac_q[28:0], sq_w[31]};
      end
      gng_pkg::OP_LN_HI: begin
        v_q   <= {t_w, 26'd0};
        res_q <= '0;
      end
      gng_pkg::OP_SQRT: begin
        if (take_w) begin
          v_q   <= 62'({2'b00, v_q} - trial_w);
          res_q <= (res_q >> 1) + bit_w;
        end else begin
          res_q <= res_q >> 1;
        end
      end
      gng_pkg::OP_X0: begin
        cz_q   <= $signed({2'b00, prod_q[60:30]});
        prod_q <= mul_p;
      end
      gng_pkg::OP_XI: begin
        cx_q <= $signed({3'b000, prod_q[60:30]});
        cy_q <= '0;
      end
      gng_pkg::OP_CORDIC: begin
        if (!cz_q[32]) begin
          cx_q <= cx_q - dx_w;
          cy_q <= cy_q + dy_w;
          cz_q <= cz_q - at_w;
        end else begin
          cx_q <= cx_q + dx_w;
          cy_q <= cy_q - dy_w;
          cz_q <= cz_q + at_w;
        end
      end
      default: begin
      end
    endcase
  end

  // Held cosine and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q       <= '0;
      out_valid_q  <= 1'b0;
      out_sample_q <= '0;
      out_fresh_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.op == gng_pkg::OP_EMIT_NEW) begin
        held_q       <= to_sample(cos_w);
        out_sample_q <= to_sample(sin_w);
        out_fresh_q  <= 1'b1;
        out_valid_q  <= 1'b1;
      end else if (cmd_i.op == gng_pkg::OP_EMIT_HELD) begin
        out_sample_q <= held_q;
        out_fresh_q  <= 1'b0;
        out_valid_q  <= 1'b1;
      end
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sample_o       = out_sample_q;
  assign fresh_pair_o   = out_fresh_q;
  assign out_valid_o    = out_valid_q;

endmodule

### hdl/gaussian_noise_generator.sv
`timescale 1ns / 1ps
// Top level of the Box-Muller Gaussian noise generator.
// Instantiates gng_ctrl and gng_dp; uses gng_pkg.
//
//  channel  | dir | tdata                              | tuser
//  s_axis   | in  | [15:0] uniform_a, [31:16] uniform_b | -
//  m_axis   | out | [15:0] sample                       | [0] fresh_pair
//
// A generating request runs 30 log2 squaring steps on the shared multiplier,
// scaling, 32 bit-serial square root steps, the angle and start values, 30
// CORDIC rotations and the load of the output; the next request is taken
// only after that result is loaded.
// The second request of a pair skips the math and returns the held cosine.
// s_axis_tready is low from a take until its result is loaded; loading waits
// while the output register still holds a result the receiver has not taken.
// Reset is asynchronous, active low; no clearing pass is needed.
module gaussian_noise_generator #(
  parameter int unsigned UNIFORM_BITS = 16,
  parameter int unsigned FRAC_BITS    = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [15:0] uniform_a, [31:16] uniform_b
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] sample
  output logic        m_axis_tuser_o    // [0] fresh_pair
);

  gng_pkg::cmd_t cmd;
  gng_pkg::sts_t sts;

  gng_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gng_dp #(
    .UNIFORM_BITS (UNIFORM_BITS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .uniform_a_i  (s_axis_tdata_i[15:0]),
    .uniform_b_i  (s_axis_tdata_i[31:16]),
    .sample_o     (m_axis_tdata_o),
    .fresh_pair_o (m_axis_tuser_o),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench for gaussian_noise_generator: drives uniform pairs on s_axis and
// checks each m_axis sample against a bit-exact Box-Muller predictor.
// Depends on hdl/gng_pkg.sv and hdl/gaussian_noise_generator.sv.

// Expected samples: predicted on input accept, checked on output accept
class gauss_scoreboard;
  bit        pair_pending;   // 1: next request generates a new pair
  bit [15:0] cos_held;
  bit [15:0] sample_q[$];
  bit        fresh_q[$];
  int        errors;

  function new();
    pair_pending = 1'b1;
    cos_held     = '0;
    errors       = 0;
  endfunction

  // Arithmetic shift right, rounding toward minus infinity
  static function longint sra64(longint v, int s);
    return v >>> s;
  endfunction

  static function longint unsigned log2_q30(longint unsigned m);
    int e;
    longint unsigned x, frac;
    e = 0;
    frac = 0;
    while (e < 63 && (m >> (e + 1)) != 0) e++;
    x = (e <= 30) ? (m << (30 - e)) : (m >> (e - 30));
    for (int k = 0; k < 30; k++) begin
      x = (x * x) >> 30;
      frac = frac << 1;
      if (x >= (64'd2 << 30)) begin
        frac = frac | 64'd1;
        x = x >> 1;
      end
    end
    return (longint'(e) << 30) | frac;
  endfunction

  static function longint unsigned isqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  static function bit [15:0] q28_to_sample(longint q28);
    longint v;
    v = sra64(q28 + (64'sd1 << (27 - 12)), 28 - 12);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // One Box-Muller pair: returns sine sample, holds cosine
  function bit [15:0] new_pair(bit [15:0] ua, bit [15:0] ub);
    longint unsigned m, lg, full, rl, tt, rad, f;
    bit [31:0] p;
    longint x, y, z, nx, c, s;
    m = longint'(ua) + 1;
    lg = log2_q30(m);
    full = 64'd16 << 30;
    rl = (lg >= full) ? 0 : full - lg;
    tt = (rl * longint'(gng_pkg::Ln2Q28)) >> 27;
    rad = isqrt(tt << 26);
    p = (32'(ub) + 32'd1) << 16;
    f = longint'(p[29:0]);
    z = longint'((f * longint'(gng_pkg::HalfPiQ30)) >> 30);
    x = longint'((rad * longint'(gng_pkg::KQ30)) >> 30);
    y = 0;
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - sra64(y, i);
        y = y + sra64(x, i);
        z = z - longint'(gng_pkg::atan_q30(5'(i)));
      end else begin
        nx = x + sra64(y, i);
        y = y - sra64(x, i);
        z = z + longint'(gng_pkg::atan_q30(5'(i)));
      end
      x = nx;
    end
    case (p[31:30])
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    cos_held = q28_to_sample(c);
    return q28_to_sample(s);
  endfunction

  function void note_request(bit [31:0] data);
    if (pair_pending) begin
      sample_q.push_back(new_pair(data[15:0], data[31:16]));
      fresh_q.push_back(1'b1);
    end else begin
      sample_q.push_back(cos_held);
      fresh_q.push_back(1'b0);
    end
    pair_pending = !pair_pending;
  endfunction

  function void check_result(bit [15:0] sample, bit fresh);
    bit [15:0] es;
    bit ef;
    if (sample_q.size() == 0) begin
      $error("unexpected result: sample %0d fresh_pair %0d", $signed(sample), fresh);
      errors++;
      return;
    end
    es = sample_q.pop_front();
    ef = fresh_q.pop_front();
    if (es !== sample) begin
      $error("sample: expected %0d, actual %0d", $signed(es), $signed(sample));
      errors++;
    end
    if (ef !== fresh) begin
      $error("fresh_pair: expected %0d, actual %0d", ef, fresh);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int NumRandom  = 1230;
  localparam int StallLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  gauss_scoreboard sb = new();
  bit  sending_done = 1'b0;
  bit  hold_off = 1'b0;
  int  idle_cycles = 0;

  gaussian_noise_generator dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o
  );

  always #5 clk_i = ~clk_i;

  // Mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  // Offer one uniform pair and wait for it to be taken
  task automatic send_uniforms(bit [15:0] ua, bit [15:0] ub);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tdata_i  <= {ub, ua};
    s_axis_tvalid_i <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Monitor: predict on every accepted request, check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) sb.note_request(s_axis_tdata_i);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
  end

  // Watchdog on cycles with no accepted transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        m_axis_tready_i <= 1'b0;
        repeat (2000) @(negedge clk_i);
        hold_off = 1'b0;
      end
      g = gap_len();
      if (g > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (g - 1) @(negedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Stimulus
  initial begin
    bit [15:0] dir_a[12] = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
                             16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'h5555,
                             16'hAAAA, 16'h1234};
    bit [15:0] dir_b[12] = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h3FFF, 16'h7FFF,
                             16'hBFFF, 16'h0000, 16'h5555, 16'hAAAA, 16'h0001,
                             16'hFFFE, 16'h8000};
    int drain;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extremes, quadrant edges, a = 1, full-turn wrap
    for (int i = 0; i < 12; i++) begin
      send_uniforms(dir_a[i], dir_b[i]);
      send_uniforms(~dir_a[i], ~dir_b[i]);
    end

    // Random, with one long receiver hold-off along the way
    for (int n = 0; n < NumRandom; n++) begin
      if (n == 300) hold_off = 1'b1;
      if ($urandom_range(0, 9) == 0)
        send_uniforms(16'($urandom_range(16'hFFF0, 16'hFFFF)), 16'($urandom));
      else
        send_uniforms(16'($urandom), 16'($urandom));
    end
    s_axis_tvalid_i <= 1'b0;
    sending_done = 1'b1;

    drain = 0;
    while (sb.sample_q.size() != 0 && drain < 200000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.sample_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
